### src/swl_pkg.sv
// ----------------------------------------------------------------------------
// swl_pkg
// types and constants shared by the stopwatch core and its time counter
// ----------------------------------------------------------------------------
package swl_pkg;

    typedef struct packed {
        logic ms_tick;
        logic start_pause_level;
        logic reset_level;
        logic lap_level;
    } t_in;

    typedef struct packed {
        logic [1:0] phase_now;
        logic [9:0] minutes;
        logic [5:0] seconds;
        logic [6:0] hundredths;
        logic [9:0] lap_minutes;
        logic [5:0] lap_seconds;
        logic [6:0] lap_hundredths;
        logic       run_led;
        logic       lap_pulse;
    } t_out;

    typedef struct packed {
        logic [9:0] minutes;
        logic [5:0] seconds;
        logic [6:0] hundredths;
    } t_time;

    typedef struct packed {
        logic clear;
        logic advance;
    } t_time_ctl;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_RUN   = 3'b010,
        PH_PAUSE = 3'b100
    } t_phase;

    localparam logic [1:0] PHASE_CODE_IDLE  = 2'd0;
    localparam logic [1:0] PHASE_CODE_RUN   = 2'd1;
    localparam logic [1:0] PHASE_CODE_PAUSE = 2'd2;

    localparam logic [3:0]  MS_LAST     = 4'd9;
    localparam logic [6:0]  HUND_LAST   = 7'd99;
    localparam logic [5:0]  SEC_LAST    = 6'd59;
    localparam logic [15:0] BLINK_RESET = 16'd500;
    localparam logic [15:0] BLINK_SAT   = 16'hFFFF;

endpackage

### src/stopwatch_with_lap_and_pause_blink_core.sv
// ----------------------------------------------------------------------------
// stopwatch_with_lap_and_pause_blink_core
// stopwatch with lap capture and a blinking run indicator while paused
// ----------------------------------------------------------------------------
// One sample is taken per clock cycle while o_in_stall is low, and its result
// appears in the output register on the following cycle; all state (phase,
// button edge memory, time counter, blink timer) is updated in a single pass
// at the accepting edge. A new sample is taken whenever the output register
// is empty or being drained. The blink half period register may be written
// at any time the block is idle and resets to 500.
module stopwatch_with_lap_and_pause_blink_core #(
    parameter int MINUTE_LIMIT = 999
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  swl_pkg::t_in  i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output swl_pkg::t_out o_out,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data
);
    import swl_pkg::*;

    t_phase      r_phase, n_phase;
    logic        r_prev_sp, r_prev_rs, r_prev_lap, n_prev_rs, n_prev_lap;
    logic [15:0] r_blink_half;
    logic [15:0] r_blink_el, n_blink_el;
    logic        r_blink_level, n_blink_level;
    logic        r_led, n_led;
    t_time       r_lap, n_lap;
    logic        pulse;
    t_time_ctl   time_ctl;
    t_time       next_time;
    logic        accept, sp_edge, rs_edge, lp_edge;
    logic [1:0]  phase_code;
    logic        r_out_valid;
    t_out        r_out;

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign accept      = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign o_cfg_ready = 1'b1;

    assign sp_edge = r_prev_sp  & ~i_in.start_pause_level;
    assign rs_edge = r_prev_rs  & ~i_in.reset_level;
    assign lp_edge = r_prev_lap & ~i_in.lap_level;

    swl_timer #(
        .MINUTE_LIMIT (MINUTE_LIMIT)
    ) u_timer (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (accept),
        .i_ctl       (time_ctl),
        .o_next_time (next_time)
    );

    always_comb begin
        n_phase       = r_phase;
        n_prev_rs     = r_prev_rs;
        n_prev_lap    = r_prev_lap;
        n_blink_level = r_blink_level;
        n_led         = r_led;
        n_lap         = r_lap;
        pulse         = 1'b0;
        time_ctl      = '0;
        n_blink_el    = r_blink_el;
        if (i_in.ms_tick && r_blink_el != BLINK_SAT) begin
            n_blink_el = r_blink_el + 16'd1;
        end
        unique case (r_phase)
            PH_RUN: begin
                time_ctl.advance = i_in.ms_tick;
                n_led = 1'b1;
            end
            PH_PAUSE: begin
                if (n_blink_el >= r_blink_half) begin
                    n_blink_el    = '0;
                    n_blink_level = ~r_blink_level;
                    n_led         = ~r_blink_level;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (sp_edge) begin
                    time_ctl.clear = 1'b1;
                    n_led   = 1'b1;
                    n_phase = PH_RUN;
                end
            end
        endcase
        if (r_phase == PH_RUN || r_phase == PH_PAUSE) begin
            if (lp_edge) begin
                n_lap = next_time;
                pulse = 1'b1;
            end
            if (sp_edge) begin
                n_phase = (r_phase == PH_RUN) ? PH_PAUSE : PH_RUN;
            end
            if (rs_edge) begin
                n_led   = 1'b0;
                n_phase = PH_IDLE;
            end
            n_prev_lap = i_in.lap_level;
            n_prev_rs  = i_in.reset_level;
        end
        unique case (n_phase)
            PH_RUN:   phase_code = PHASE_CODE_RUN;
            PH_PAUSE: phase_code = PHASE_CODE_PAUSE;
            default:  phase_code = PHASE_CODE_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_prev_sp     <= 1'b1;
            r_prev_rs     <= 1'b1;
            r_prev_lap    <= 1'b1;
            r_blink_el    <= '0;
            r_blink_level <= 1'b0;
            r_led         <= 1'b0;
            r_lap         <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (accept) begin
                r_phase       <= n_phase;
                r_prev_sp     <= i_in.start_pause_level;
                r_prev_rs     <= n_prev_rs;
                r_prev_lap    <= n_prev_lap;
                r_blink_el    <= n_blink_el;
                r_blink_level <= n_blink_level;
                r_led         <= n_led;
                r_lap         <= n_lap;
                r_out_valid   <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blink_half <= BLINK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_blink_half <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out.phase_now      <= phase_code;
            r_out.minutes        <= next_time.minutes;
            r_out.seconds        <= next_time.seconds;
            r_out.hundredths     <= next_time.hundredths;
            r_out.lap_minutes    <= n_lap.minutes;
            r_out.lap_seconds    <= n_lap.seconds;
            r_out.lap_hundredths <= n_lap.hundredths;
            r_out.run_led        <= n_led;
            r_out.lap_pulse      <= pulse;
        end
    end

endmodule

### src/swl_timer.sv
// ----------------------------------------------------------------------------
// swl_timer
// elapsed time counter: milliseconds, hundredths, seconds, saturating minutes
// ----------------------------------------------------------------------------
module swl_timer #(
    parameter int MINUTE_LIMIT = 999
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  swl_pkg::t_time_ctl i_ctl,
    output swl_pkg::t_time     o_next_time
);
    import swl_pkg::*;

    localparam int MW = $clog2(MINUTE_LIMIT + 1);
    localparam logic [MW-1:0] MIN_LIMIT = MW'(MINUTE_LIMIT);

    logic [3:0]    r_ms,   n_ms;
    logic [6:0]    r_hund, n_hund;
    logic [5:0]    r_sec,  n_sec;
    logic [MW-1:0] r_min,  n_min;
    logic          sat;

    always_comb begin
        n_ms   = r_ms;
        n_hund = r_hund;
        n_sec  = r_sec;
        n_min  = r_min;
        sat = (r_min >= MIN_LIMIT) && (r_sec >= SEC_LAST) &&
              (r_hund >= HUND_LAST) && (r_ms >= MS_LAST);
        if (i_ctl.clear) begin
            n_ms   = '0;
            n_hund = '0;
            n_sec  = '0;
            n_min  = '0;
        end else if (i_ctl.advance && !sat) begin
            if (r_ms < MS_LAST) begin
                n_ms = r_ms + 4'd1;
            end else begin
                n_ms = '0;
                if (r_hund < HUND_LAST) begin
                    n_hund = r_hund + 7'd1;
                end else begin
                    n_hund = '0;
                    if (r_sec < SEC_LAST) begin
                        n_sec = r_sec + 6'd1;
                    end else begin
                        n_sec = '0;
                        n_min = r_min + MW'(1);
                    end
                end
            end
        end
        o_next_time.minutes    = 10'(n_min);
        o_next_time.seconds    = n_sec;
        o_next_time.hundredths = n_hund;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms   <= '0;
            r_hund <= '0;
            r_sec  <= '0;
            r_min  <= '0;
        end else if (i_en) begin
            r_ms   <= n_ms;
            r_hund <= n_hund;
            r_sec  <= n_sec;
            r_min  <= n_min;
        end
    end

endmodule
